// ===== hdl/nrc_pkg.sv =====
package nrc_pkg;

	// Longest body accepted before the sentence is dropped as too long.
	localparam logic [7:0] MAX_SENTENCE = 8'd128;
	// A body shorter than this cannot carry the "xxRMC" talker and type.
	localparam logic [7:0] MIN_RMC_BODY = 8'd5;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_C      = 8'h43;

	localparam logic [4:0] FIELD_TIME = 5'd1;
	localparam logic [4:0] FIELD_DATE = 5'd9;
	localparam logic [4:0] FIELD_MAX  = 5'd31;
	localparam logic [3:0] CHAR_MAX   = 4'd15;
	localparam logic [3:0] DIGITS_KEPT = 4'd6;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_BODY = 2'd1,
		PH_CSUM = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_RMC      = 2'd0,
		ST_OTHER    = 2'd1,
		ST_CSUM_ERR = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	// Checksum character count codes.
	localparam logic [1:0] CS_TWO = 2'd2;
	localparam logic [1:0] CS_BAD = 2'd3;

	// One stored field character, reduced to "is a digit" and its value.
	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} digit_t;

	// Sentence snapshot handed to the report builder.
	typedef struct packed {
		logic             rmc;
		digit_t [5:0]     tdig;
		digit_t [5:0]     ddig;
	} ctx_t;

	typedef struct packed {
		status_t     status;
		logic [6:0]  hours;
		logic [6:0]  minutes;
		logic [6:0]  seconds;
		logic [6:0]  day;
		logic [6:0]  month;
		logic [6:0]  year;
		logic [15:0] errors_seen;
	} report_t;

	function automatic digit_t to_digit(input logic [7:0] c);
		digit_t d;
		d.ok  = c inside {[8'h30:8'h39]};
		d.val = c[3:0];
		return d;
	endfunction

	// {valid, nibble} for an uppercase hex character.
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, c[3:0]};
		end else if (c inside {[8'h41:8'h46]}) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic logic pair_ok(input digit_t hi, input digit_t lo);
		return hi.ok && lo.ok;
	endfunction

	function automatic logic [6:0] pair_value(input digit_t hi, input digit_t lo);
		return 7'(hi.val) * 7'd10 + 7'(lo.val);
	endfunction

endpackage

// ===== hdl/nrc_in_if.sv =====
interface nrc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/nrc_out_if.sv =====
interface nrc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [6:0]  hours;
	logic [6:0]  minutes;
	logic [6:0]  seconds;
	logic [6:0]  day;
	logic [6:0]  month;
	logic [6:0]  year;
	logic [15:0] errors_seen;

	modport source (output valid, output status, output hours, output minutes,
		output seconds, output day, output month, output year, output errors_seen,
		input ready);
	modport sink (input valid, input status, input hours, input minutes,
		input seconds, input day, input month, input year, input errors_seen,
		output ready);
endinterface

// ===== hdl/nmea_rmc_checksum_parser.sv =====
// Channel  Dir  Payload                                    Transaction
// -------  ---  -----------------------------------------  ---------------------------
// stream   in   rx_byte[7:0]                               one received byte
// report   out  status, hours..year (7b each), errors_seen  one per ended sentence
//
// Every byte is registered in stage 1 and processed from there; one byte
// per cycle is sustained while report is not stalled. A result, when a
// byte ends a sentence, sits in the output register, and stage 1 keeps
// moving while that register is empty or being drained. A stalled report
// holds stage 1 and then stream. arst_n clears phase, counters, the error total and all valid flags.
module nmea_rmc_checksum_parser
	import nrc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	nrc_in_if.sink   stream,
	nrc_out_if.source report
);

	// Stage 1: registered input byte.
	logic [7:0] byte_s1;
	logic       valid_s1;

	// Sentence state.
	phase_t       phase_q;
	logic [7:0]   xor_q;
	logic [7:0]   body_cnt_q;
	logic [4:0]   field_q;
	logic [3:0]   char_q;
	logic         type_ok_q;
	digit_t [5:0] tdig_q;
	digit_t [5:0] ddig_q;
	logic [7:0]   csum_rx_q;
	logic [1:0]   csum_chars_q;
	logic [15:0]  err_total_q;

	// Output register.
	logic    out_valid_q;
	report_t out_q;

	logic       can_take;
	logic       advance;
	logic       is_start;
	logic       is_eol;
	logic       body_byte;
	logic       too_long;
	logic       eol_hit;
	logic       csum_bad;
	logic       emit;
	logic       emit_err;
	logic       capture;
	logic [4:0] hex;
	status_t    status;
	logic [15:0] err_next;
	ctx_t       ctx;
	report_t    rep;

	// Output register drains or is empty: stage 1 may move on.
	assign can_take     = !out_valid_q || report.ready;
	assign advance      = valid_s1 && can_take;
	assign stream.ready = !valid_s1 || can_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.rx_byte;
		end
	end

	// Decode the byte against the current phase.
	assign is_start  = (byte_s1 == CH_DOLLAR);
	assign is_eol    = (byte_s1 == CH_CR) || (byte_s1 == CH_LF);
	assign too_long  = (phase_q == PH_BODY) && !is_start && (byte_s1 != CH_STAR)
		&& (body_cnt_q >= MAX_SENTENCE);
	assign body_byte = (phase_q == PH_BODY) && !is_start && (byte_s1 != CH_STAR)
		&& !too_long;
	assign eol_hit   = (phase_q == PH_CSUM) && !is_start && is_eol;
	assign csum_bad  = (csum_chars_q != CS_TWO) || (csum_rx_q != xor_q);
	assign emit      = too_long || eol_hit;
	assign emit_err  = too_long || (eol_hit && csum_bad);
	assign hex       = hex_nibble(byte_s1);
	assign capture   = body_byte && (byte_s1 != CH_COMMA) && (char_q < DIGITS_KEPT);
	assign err_next  = err_total_q + 16'd1;

	always_comb begin
		if (too_long) begin
			status = ST_TOO_LONG;
		end else if (csum_bad) begin
			status = ST_CSUM_ERR;
		end else if (type_ok_q && (body_cnt_q >= MIN_RMC_BODY)) begin
			status = ST_RMC;
		end else begin
			status = ST_OTHER;
		end
	end

	assign ctx.rmc  = (status == ST_RMC);
	assign ctx.tdig = tdig_q;
	assign ctx.ddig = ddig_q;

	nrc_report u_report (
		.status (status),
		.ctx    (ctx),
		.errors (emit_err ? err_next : err_total_q),
		.rep    (rep)
	);

	// Control state: phase, counters, checksum, error total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			xor_q        <= '0;
			body_cnt_q   <= '0;
			field_q      <= '0;
			char_q       <= '0;
			type_ok_q    <= 1'b0;
			csum_rx_q    <= '0;
			csum_chars_q <= '0;
			err_total_q  <= '0;
		end else if (advance) begin
			if (is_start) begin
				// '$' restarts from any phase, silently.
				phase_q      <= PH_BODY;
				xor_q        <= '0;
				body_cnt_q   <= '0;
				field_q      <= '0;
				char_q       <= '0;
				type_ok_q    <= 1'b1;
				csum_rx_q    <= '0;
				csum_chars_q <= '0;
			end else begin
				case (phase_q)
					PH_BODY: begin
						if (byte_s1 == CH_STAR) begin
							phase_q      <= PH_CSUM;
							csum_rx_q    <= '0;
							csum_chars_q <= '0;
						end else if (too_long) begin
							phase_q     <= PH_HUNT;
							err_total_q <= err_next;
						end else begin
							xor_q      <= xor_q ^ byte_s1;
							body_cnt_q <= body_cnt_q + 8'd1;
							// Body characters 2..4 must spell the sentence type.
							if ((body_cnt_q == 8'd2 && byte_s1 != CH_R)
								|| (body_cnt_q == 8'd3 && byte_s1 != CH_M)
								|| (body_cnt_q == 8'd4 && byte_s1 != CH_C)) begin
								type_ok_q <= 1'b0;
							end
							if (byte_s1 == CH_COMMA) begin
								if (field_q != FIELD_MAX) begin
									field_q <= field_q + 5'd1;
								end
								char_q <= '0;
							end else if (char_q != CHAR_MAX) begin
								char_q <= char_q + 4'd1;
							end
						end
					end
					PH_CSUM: begin
						if (is_eol) begin
							phase_q <= PH_HUNT;
							if (csum_bad) begin
								err_total_q <= err_next;
							end
						end else if (csum_chars_q < CS_TWO && hex[4]) begin
							csum_rx_q    <= {csum_rx_q[3:0], hex[3:0]};
							csum_chars_q <= csum_chars_q + 2'd1;
						end else begin
							// Non-hex or a third character: mark malformed.
							csum_chars_q <= CS_BAD;
						end
					end
					default: begin
						phase_q <= PH_HUNT;
					end
				endcase
			end
		end
	end

	// Field digits: cleared by '$', written while inside field 1 or 9.
	always_ff @(posedge clk) begin
		if (advance) begin
			if (is_start) begin
				tdig_q <= '0;
				ddig_q <= '0;
			end else if (capture) begin
				if (field_q == FIELD_TIME) begin
					tdig_q[char_q[2:0]] <= to_digit(byte_s1);
				end else if (field_q == FIELD_DATE) begin
					ddig_q[char_q[2:0]] <= to_digit(byte_s1);
				end
			end
		end
	end

	// Result register: load on a sentence end, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= rep;
		end
	end

	assign report.valid       = out_valid_q;
	assign report.status      = out_q.status;
	assign report.hours       = out_q.hours;
	assign report.minutes     = out_q.minutes;
	assign report.seconds     = out_q.seconds;
	assign report.day         = out_q.day;
	assign report.month       = out_q.month;
	assign report.year        = out_q.year;
	assign report.errors_seen = out_q.errors_seen;

endmodule

// ===== hdl/nrc_report.sv =====
module nrc_report
	import nrc_pkg::*;
(
	input  status_t     status,
	input  ctx_t        ctx,
	input  logic [15:0] errors,
	output report_t     rep
);

	logic time_ok;
	logic day_ok;
	logic month_ok;
	logic year_ok;
	logic show;

	assign show     = ctx.rmc;
	assign time_ok  = pair_ok(ctx.tdig[0], ctx.tdig[1]) && pair_ok(ctx.tdig[2], ctx.tdig[3])
		&& pair_ok(ctx.tdig[4], ctx.tdig[5]);
	// Date fields validate left to right: a bad day hides month and year.
	assign day_ok   = pair_ok(ctx.ddig[0], ctx.ddig[1]);
	assign month_ok = day_ok && pair_ok(ctx.ddig[2], ctx.ddig[3]);
	assign year_ok  = month_ok && pair_ok(ctx.ddig[4], ctx.ddig[5]);

	always_comb begin
		rep             = '0;
		rep.status      = status;
		rep.errors_seen = errors;
		if (show && time_ok) begin
			rep.hours   = pair_value(ctx.tdig[0], ctx.tdig[1]);
			rep.minutes = pair_value(ctx.tdig[2], ctx.tdig[3]);
			rep.seconds = pair_value(ctx.tdig[4], ctx.tdig[5]);
		end
		if (show && day_ok) begin
			rep.day = pair_value(ctx.ddig[0], ctx.ddig[1]);
		end
		if (show && month_ok) begin
			rep.month = pair_value(ctx.ddig[2], ctx.ddig[3]);
		end
		if (show && year_ok) begin
			rep.year = pair_value(ctx.ddig[4], ctx.ddig[5]);
		end
	end

endmodule
